// ===== design/lrucv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrucv_pkg
// Shared types and codes of the L1 plus victim buffer tag engine.
// ----------------------------------------------------------------------------
package lrucv_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned VC_CNT_W  = 4;
  localparam int unsigned VC_AGE_W  = 8;
  localparam logic [VC_AGE_W-1:0] VC_AGE_CAP = 8'd255;

  localparam logic [VC_CNT_W-1:0] VC_CNT_RESET = 4'd8;
  localparam logic                L2_EN_RESET  = 1'b1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic REG_VC_COUNT = 1'b0;
  localparam logic REG_L2_EN    = 1'b1;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef struct packed {
    logic [VC_CNT_W-1:0] vc_count;
    logic                l2_en;
  } cfg_t;

  typedef struct packed {
    logic              l1_hit;
    logic              swap_request;
    logic              swap_done;
    logic              dirty_eviction;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_address;
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_address;
  } res_t;

endpackage

// ===== design/lru_cache_with_victim_buffer.sv =====
// ----------------------------------------------------------------------------
// lru_cache_with_victim_buffer
// Tag and state engine of a write-back set-associative L1 with LRU and a
// fully associative victim buffer.
// ----------------------------------------------------------------------------
// Flow: the back engine pops a request and reads the per-way tag RAMs and
// the set state RAM, then writes them back and loads the result register,
// waiting while the result is stalled; no new request is taken before then.
// Reset: valid, dirty and age state clear at once, no clearing pass; victim
// count resets to 8 and next-level requests are enabled.
module lru_cache_with_victim_buffer #(
  parameter int unsigned SETS           = 64,
  parameter int unsigned WAYS           = 4,
  parameter int unsigned VICTIM_ENTRIES = 8,
  parameter int unsigned OFFSET_BITS    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        l1_hit_o,
  output logic        swap_request_o,
  output logic        swap_done_o,
  output logic        dirty_eviction_o,
  output logic        writeback_valid_o,
  output logic [31:0] writeback_address_o,
  output logic        fetch_valid_o,
  output logic [31:0] fetch_address_o
);

  lrucv_pkg::cfg_t  cfg_q;
  lrucv_pkg::item_t in_item, q_item;
  lrucv_pkg::res_t  res;
  logic             q_valid, q_pop, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vc_count <= lrucv_pkg::VC_CNT_RESET;
      cfg_q.l2_en    <= lrucv_pkg::L2_EN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lrucv_pkg::REG_VC_COUNT: cfg_q.vc_count <= pwdata[3:0];
        lrucv_pkg::REG_L2_EN:    cfg_q.l2_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lrucv_pkg::REG_VC_COUNT: prdata = {28'd0, cfg_q.vc_count};
      lrucv_pkg::REG_L2_EN:    prdata = {31'd0, cfg_q.l2_en};
      default:                 prdata = '0;
    endcase
  end

  assign in_item.op   = operation_i;
  assign in_item.addr = address_i;

  lrucv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .item_i    (in_item),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  lrucv_back #(
    .SETS          (SETS),
    .WAYS          (WAYS),
    .VICTIM_ENTRIES(VICTIM_ENTRIES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .res_valid_o(out_valid_o),
    .res_o      (res),
    .res_stall_i(out_stall_i)
  );

  assign l1_hit_o            = res.l1_hit;
  assign swap_request_o      = res.swap_request;
  assign swap_done_o         = res.swap_done;
  assign dirty_eviction_o    = res.dirty_eviction;
  assign writeback_valid_o   = res.writeback_valid;
  assign writeback_address_o = res.writeback_address;
  assign fetch_valid_o       = res.fetch_valid;
  assign fetch_address_o     = res.fetch_address;

  // a swap only happens after a full-set miss was sent to the victim buffer
  a_swap_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && swap_done_o |-> swap_request_o && !l1_hit_o && !fetch_valid_o)
    else $error("swap without swap request");

  a_hit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && l1_hit_o |-> !swap_request_o && !dirty_eviction_o && !fetch_valid_o)
    else $error("hit raised miss activity");

  a_wb_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_valid_o |-> dirty_eviction_o && cfg_q.l2_en)
    else $error("write-back without dirty eviction");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("back engine popped twice in a row");

endmodule

// ===== design/lrucv_ram.sv =====
// ----------------------------------------------------------------------------
// lrucv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrucv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lrucv_front.sv =====
// ----------------------------------------------------------------------------
// lrucv_front
// Access intake: takes request words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lrucv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lrucv_pkg::item_t    item_i,
  output logic                q_valid_o,
  output lrucv_pkg::item_t    q_item_o,
  input  logic                q_pop_i
);

  lrucv_pkg::item_t buf_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop  ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== design/lrucv_back.sv =====
// ----------------------------------------------------------------------------
// lrucv_back
// Lookup and update engine: reads a set, resolves L1 and victim buffer,
// writes the new state back and loads the result register.
// ----------------------------------------------------------------------------
module lrucv_back #(
  parameter int unsigned SETS           = 64,
  parameter int unsigned WAYS           = 4,
  parameter int unsigned VICTIM_ENTRIES = 8,
  parameter int unsigned OFFSET_BITS    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrucv_pkg::cfg_t  cfg_i,
  input  logic             q_valid_i,
  input  lrucv_pkg::item_t q_item_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  output lrucv_pkg::res_t  res_o,
  input  logic             res_stall_i
);

  localparam int unsigned IDX    = $clog2(SETS + 1) - 1;
  localparam int unsigned NSETS  = 1 << IDX;
  localparam int unsigned SET_W  = (IDX > 0) ? IDX : 1;
  localparam int unsigned TAG_W  = lrucv_pkg::ADDR_W - OFFSET_BITS - IDX;
  localparam int unsigned VT_W   = lrucv_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned AW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VE_W   = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int unsigned ROW_W  = WAYS * (1 + AW);
  localparam int unsigned VA_W   = lrucv_pkg::VC_AGE_W;

  lrucv_pkg::bk_state_e state_q, state_d;
  lrucv_pkg::item_t     cur_q;
  lrucv_pkg::res_t      res_q, res_d;
  logic                 res_valid_q;
  logic                 out_free, commit, rd_en;

  logic [SET_W-1:0] rd_set, cur_set;
  logic [TAG_W-1:0] cur_tag;
  logic [VT_W-1:0]  cur_blk;

  logic [WAYS-1:0]  l1_valid_q [NSETS];
  logic [WAYS-1:0]  vld_row, vld_row_d;
  logic [TAG_W-1:0] tag_rd [WAYS];
  logic [ROW_W-1:0] row_rd, row_wd;
  logic [WAYS-1:0]  tag_we;

  logic [VT_W-1:0] vtag_q  [VICTIM_ENTRIES];
  logic [VT_W-1:0] vtag_d  [VICTIM_ENTRIES];
  logic [VICTIM_ENTRIES-1:0] vvalid_q, vvalid_d, vdirty_q, vdirty_d;
  logic [VA_W-1:0] vage_q  [VICTIM_ENTRIES];
  logic [VA_W-1:0] vage_d  [VICTIM_ENTRIES];

  assign rd_set  = SET_W'(q_item_i.addr >> OFFSET_BITS) & SET_W'(NSETS - 1);
  assign cur_set = SET_W'(cur_q.addr >> OFFSET_BITS) & SET_W'(NSETS - 1);
  assign cur_tag = TAG_W'(cur_q.addr >> (OFFSET_BITS + IDX));
  assign cur_blk = VT_W'(cur_q.addr >> OFFSET_BITS);
  assign vld_row = l1_valid_q[cur_set];

  for (genvar w = 0; w < WAYS; w++) begin : g_tag
    lrucv_ram #(.WIDTH(TAG_W), .DEPTH(NSETS)) u_tag_ram (
      .clk_i  (clk_i),
      .we_i   (tag_we[w]),
      .waddr_i(cur_set),
      .wdata_i(cur_tag),
      .re_i   (rd_en),
      .raddr_i(rd_set),
      .rdata_o(tag_rd[w])
    );
  end

  // per set: dirty bits above, way ages below
  lrucv_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (commit),
    .waddr_i(cur_set),
    .wdata_i(row_wd),
    .re_i   (rd_en),
    .raddr_i(rd_set),
    .rdata_o(row_rd)
  );

  assign out_free = !res_valid_q || !res_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrucv_pkg::BK_IDLE: if (q_valid_i) state_d = lrucv_pkg::BK_EXEC;
      lrucv_pkg::BK_EXEC: if (out_free)  state_d = lrucv_pkg::BK_IDLE;
      default:            state_d = lrucv_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    rd_en  = 1'b0;
    commit = 1'b0;
    unique case (state_q)
      lrucv_pkg::BK_IDLE: rd_en  = q_valid_i;
      lrucv_pkg::BK_EXEC: commit = out_free;
      default: ;
    endcase
  end

  assign q_pop_o = rd_en;

  // datapath: lookup, replacement choice and next state
  always_comb begin
    logic [AW-1:0]     age   [WAYS];
    logic [AW-1:0]     age_n [WAYS];
    logic [WAYS-1:0]   dty, dty_n, hit_vec;
    logic              hit, free_any, wr, ev_dirty, new_dirty;
    logic [AW-1:0]     hit_way, free_way, lru, tgt, old_age;
    logic [lrucv_pkg::ADDR_W-1:0] ev_addr, wb_addr;
    logic              sreq, sdone, dout, fetch, vhit, vfree;
    logic [VE_W-1:0]   ent, vlru;
    logic [VA_W-1:0]   vold;
    logic [5:0]        n;
    logic              en;

    wr = (cur_q.op == lrucv_pkg::OP_WRITE);
    for (int w = 0; w < WAYS; w++) begin
      age[w]     = vld_row[w] ? row_rd[w*AW +: AW] : '0;
      dty[w]     = vld_row[w] && row_rd[WAYS*AW + w];
      hit_vec[w] = vld_row[w] && (tag_rd[w] == cur_tag);
    end
    hit = |hit_vec;
    free_any = !(&vld_row);
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = AW'(w);
      if (!vld_row[w]) free_way = AW'(w);
    end
    lru = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (age[w] > age[lru]) lru = AW'(w);
    end

    n = ({2'b00, cfg_i.vc_count} > 6'(VICTIM_ENTRIES)) ? 6'(VICTIM_ENTRIES)
                                                      : {2'b00, cfg_i.vc_count};
    ev_addr  = (32'(tag_rd[lru]) << (OFFSET_BITS + IDX)) | (32'(cur_set) << OFFSET_BITS);
    ev_dirty = dty[lru];
    new_dirty = wr;
    sreq = 1'b0; sdone = 1'b0; dout = 1'b0; fetch = 1'b0;
    wb_addr = '0;
    vhit = 1'b0; vfree = 1'b0; ent = '0; vlru = '0;
    old_age = '0;
    vold = '0;
    vtag_d = vtag_q; vvalid_d = vvalid_q; vdirty_d = vdirty_q; vage_d = vage_q;
    dty_n = dty;
    age_n = age;
    vld_row_d = vld_row;
    tag_we = '0;
    tgt = lru;

    for (int e = VICTIM_ENTRIES - 1; e >= 0; e--) begin
      if (6'(e) < n && vvalid_q[e] && vtag_q[e] == cur_blk) begin
        vhit = 1'b1; ent = VE_W'(e);
      end
    end
    for (int e = 1; e < VICTIM_ENTRIES; e++) begin
      if (6'(e) < n && vage_q[e] > vage_q[vlru]) vlru = VE_W'(e);
    end

    if (hit) begin
      tgt = hit_way;
      if (wr) dty_n[hit_way] = 1'b1;
      old_age = age[hit_way];
      for (int w = 0; w < WAYS; w++) begin
        if (AW'(w) != hit_way && vld_row[w] && age[w] <= old_age) age_n[w] = age[w] + 1'b1;
      end
      age_n[hit_way] = '0;
    end else begin
      tgt = free_any ? free_way : lru;
      if (!free_any && n != 6'd0) begin
        sreq = 1'b1;
        if (vhit) begin
          sdone = 1'b1;
          if (!wr) new_dirty = vdirty_q[ent];
          vtag_d[ent]   = ev_addr[lrucv_pkg::ADDR_W-1:OFFSET_BITS];
          vdirty_d[ent] = ev_dirty;
          vold = vage_q[ent];
          for (int e = 0; e < VICTIM_ENTRIES; e++) begin
            if (6'(e) < n && VE_W'(e) != ent && vvalid_q[e] && vage_q[e] <= vold &&
                vage_q[e] != lrucv_pkg::VC_AGE_CAP) vage_d[e] = vage_q[e] + 1'b1;
          end
          vage_d[ent] = '0;
        end else begin
          for (int e = VICTIM_ENTRIES - 1; e >= 0; e--) begin
            if (6'(e) < n && !vvalid_q[e]) begin
              vfree = 1'b1; ent = VE_W'(e);
            end
          end
          if (!vfree) begin
            ent = vlru;
            if (vdirty_q[vlru]) begin
              dout = 1'b1;
              wb_addr = 32'(vtag_q[vlru]) << OFFSET_BITS;
            end
          end
          fetch = 1'b1;
          vtag_d[ent]   = ev_addr[lrucv_pkg::ADDR_W-1:OFFSET_BITS];
          vvalid_d[ent] = 1'b1;
          vdirty_d[ent] = ev_dirty;
          for (int e = 0; e < VICTIM_ENTRIES; e++) begin
            if (6'(e) < n && VE_W'(e) != ent && vvalid_q[e] &&
                vage_q[e] != lrucv_pkg::VC_AGE_CAP) vage_d[e] = vage_q[e] + 1'b1;
          end
          vage_d[ent] = '0;
        end
      end else begin
        fetch = 1'b1;
        if (!free_any && ev_dirty) begin
          dout = 1'b1;
          wb_addr = ev_addr;
        end
      end
      tag_we[tgt]    = commit;
      vld_row_d[tgt] = 1'b1;
      dty_n[tgt]     = new_dirty;
      for (int w = 0; w < WAYS; w++) begin
        age_n[w] = age[w] + 1'b1;
      end
      age_n[tgt] = '0;
    end

    for (int w = 0; w < WAYS; w++) begin
      row_wd[w*AW +: AW]   = age_n[w];
      row_wd[WAYS*AW + w]  = dty_n[w];
    end

    en = cfg_i.l2_en;
    res_d.l1_hit            = hit;
    res_d.swap_request      = sreq;
    res_d.swap_done         = sdone;
    res_d.dirty_eviction    = dout;
    res_d.writeback_valid   = dout && en;
    res_d.writeback_address = (dout && en) ? wb_addr : '0;
    res_d.fetch_valid       = fetch && en;
    res_d.fetch_address     = (fetch && en) ? cur_q.addr : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrucv_pkg::BK_IDLE;
      res_valid_q <= 1'b0;
      vvalid_q    <= '0;
      vdirty_q    <= '0;
      for (int e = 0; e < VICTIM_ENTRIES; e++) vage_q[e] <= '0;
      for (int s = 0; s < NSETS; s++) l1_valid_q[s] <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
      if (commit) begin
        vvalid_q            <= vvalid_d;
        vdirty_q            <= vdirty_d;
        vage_q              <= vage_d;
        l1_valid_q[cur_set] <= vld_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) cur_q <= q_item_i;
    if (commit) begin
      res_q  <= res_d;
      vtag_q <= vtag_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
